### rtl/dsfa_pkg.sv
// Package for the dust sensor frame averager: frame constants, widths and
// the command and status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsfa_pkg;

  // Frame layout and framing bytes.
  localparam int unsigned FrameLen   = 10;
  localparam logic [7:0]  StartByte  = 8'hAA;
  localparam logic [7:0]  CmdByte    = 8'hC0;
  localparam logic [7:0]  TailByte   = 8'hAB;

  // The stored-byte position wraps to zero at this count.
  localparam logic [7:0]  PositionWrap = 8'd250;

  // Averaging register reset value and the sample count that forces an average.
  localparam logic [7:0]  SamplesReset = 8'd10;
  localparam logic [7:0]  CountLimit   = 8'hFF;

  // Running sums and the divider.
  localparam int unsigned SumW     = 24;
  localparam int unsigned AvgW     = 16;
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_byte;  // input beat accepted: shift byte into window
    logic eval;       // check frame, update sums, maybe start divide
    logic div_step;   // one quotient bit per cycle
    logic out_load;   // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic avg_due;    // valid during eval: an average has to be computed
    logic div_last;   // valid during divide: this is the final step
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/dsfa_ctrl.sv
// Controller state machine of the dust sensor frame averager.
// Depends on dsfa_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module dsfa_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  wire               m_ready_i,
  input  dsfa_pkg::dp_stat_t stat_i,
  output dsfa_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   s_ready_q;
  logic   m_valid_q;
  logic   out_free;

  assign s_ready_o = s_ready_q;
  assign m_valid_o = m_valid_q;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !m_valid_q || m_ready_i;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o.load_byte = s_valid_i && s_ready_q;
    cmd_o.eval      = (state_q == ST_EVAL);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.out_load  = (state_q == ST_DONE) && out_free;
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      s_ready_q <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      // Deliver a new beat, or retire the one the sink has taken.
      if ((state_q == ST_DONE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_valid_i && s_ready_q) begin
            state_q   <= ST_EVAL;
            s_ready_q <= 1'b0;
          end
        end
        ST_EVAL: begin
          state_q <= stat_i.avg_due ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (stat_i.div_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            s_ready_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // An accepted beat always starts an evaluation.
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_q) |=> (state_q == ST_EVAL))
    else $error("accepted beat did not start evaluation");

  // The input side is open only while idle.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_ready_q |-> (state_q == ST_IDLE))
    else $error("input ready outside idle");

  // The last divide step hands over to result delivery.
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && stat_i.div_last) |=> (state_q == ST_DONE))
    else $error("divide did not finish into delivery");

endmodule

`default_nettype wire

### rtl/dsfa_datapath.sv
// Datapath of the dust sensor frame averager: byte window, position,
// running sums, sample count, restoring dividers for both sums and output register.
// Depends on dsfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsfa_datapath #(
  parameter logic [7:0] PositionWrap = dsfa_pkg::PositionWrap
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  dsfa_pkg::dp_cmd_t  cmd_i,
  output dsfa_pkg::dp_stat_t stat_o,
  input  wire                cfg_we_i,
  input  wire [7:0]          cfg_data_i,
  input  wire [7:0]          rx_byte_i,
  input  wire                measurement_window_i,
  output logic               frame_valid_o,
  output logic               sample_taken_o,
  output logic               average_ready_o,
  output logic [dsfa_pkg::AvgW-1:0] pm25_average_o,
  output logic [dsfa_pkg::AvgW-1:0] pm10_average_o
);

  localparam int unsigned SumW = dsfa_pkg::SumW;
  localparam int unsigned AvgW = dsfa_pkg::AvgW;

  logic [7:0]  spa_q;
  logic [7:0]  win_q [dsfa_pkg::FrameLen];
  logic [7:0]  byte_q;
  logic        mwin_q;
  logic [7:0]  pos_q;
  logic [SumW-1:0] sum25_q, sum10_q;
  logic [7:0]  cnt_q;

  // Per-item result flags.
  logic res_valid_q, res_taken_q, res_ready_q;

  // Divider state.
  logic [SumW-1:0] quo25_q, quo10_q;
  logic [7:0]      rem25_q, rem10_q;
  logic [7:0]      divisor_q;
  logic [dsfa_pkg::DivCntW-1:0] div_cnt_q;

  // Frame check on the shifted window.
  logic [7:0]      chk;
  logic            good;
  logic            taken;
  logic [SumW-1:0] sum25_n, sum10_n;
  logic [7:0]      cnt_n;
  logic [7:0]      need;
  logic            due;

  always_comb begin
    chk = win_q[2] + win_q[3] + win_q[4] + win_q[5] + win_q[6] + win_q[7];
    good = (byte_q == dsfa_pkg::TailByte) && (pos_q >= 8'(dsfa_pkg::FrameLen))
        && (win_q[0] == dsfa_pkg::StartByte) && (win_q[1] == dsfa_pkg::CmdByte)
        && (win_q[9] == dsfa_pkg::TailByte) && (win_q[8] == chk);
    taken   = good && mwin_q;
    sum25_n = sum25_q + {8'd0, win_q[3], win_q[2]};
    sum10_n = sum10_q + {8'd0, win_q[5], win_q[4]};
    cnt_n   = cnt_q + 8'd1;
    need    = (spa_q == 8'd0) ? 8'd1 : spa_q;
    due     = taken && ((cnt_n >= need) || (cnt_n == dsfa_pkg::CountLimit));
  end

  assign stat_o.avg_due  = due;
  assign stat_o.div_last = (div_cnt_q == dsfa_pkg::DivCntW'(dsfa_pkg::DivSteps - 1));

  // One restoring divide step for each of the two sums.
  logic [8:0] sh25, sh10;
  logic       ge25, ge10;
  always_comb begin
    sh25 = {rem25_q, quo25_q[SumW-1]};
    sh10 = {rem10_q, quo10_q[SumW-1]};
    ge25 = sh25 >= {1'b0, divisor_q};
    ge10 = sh10 >= {1'b0, divisor_q};
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spa_q <= dsfa_pkg::SamplesReset;
    end else if (cfg_we_i) begin
      spa_q <= cfg_data_i;
    end
  end

  // Byte window: shifts only once a start byte has opened a run.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= rx_byte_i;
      mwin_q <= measurement_window_i;
      if ((pos_q != 8'd0) || (rx_byte_i == dsfa_pkg::StartByte)) begin
        for (int i = 0; i < dsfa_pkg::FrameLen - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[dsfa_pkg::FrameLen-1] <= rx_byte_i;
      end
    end
  end

  // Position, sums and sample count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 8'd0;
      sum25_q <= '0;
      sum10_q <= '0;
      cnt_q   <= 8'd0;
    end else if (cmd_i.load_byte) begin
      if ((pos_q != 8'd0) || (rx_byte_i == dsfa_pkg::StartByte)) begin
        pos_q <= pos_q + 8'd1;
      end
    end else if (cmd_i.eval) begin
      if (good || (pos_q == PositionWrap)) begin
        pos_q <= 8'd0;
      end
      if (due) begin
        sum25_q <= '0;
        sum10_q <= '0;
        cnt_q   <= 8'd0;
      end else if (taken) begin
        sum25_q <= sum25_n;
        sum10_q <= sum10_n;
        cnt_q   <= cnt_n;
      end
    end
  end

  // Result flags and the divider.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      res_valid_q <= good;
      res_taken_q <= taken;
      res_ready_q <= due;
      quo25_q     <= sum25_n;
      quo10_q     <= sum10_n;
      rem25_q     <= 8'd0;
      rem10_q     <= 8'd0;
      divisor_q   <= (cnt_n == 8'd0) ? 8'd1 : cnt_n;
      div_cnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      quo25_q   <= {quo25_q[SumW-2:0], ge25};
      quo10_q   <= {quo10_q[SumW-2:0], ge10};
      rem25_q   <= ge25 ? 8'(sh25 - {1'b0, divisor_q}) : sh25[7:0];
      rem10_q   <= ge10 ? 8'(sh10 - {1'b0, divisor_q}) : sh10[7:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // Output register, saturating the quotients to the average width.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      frame_valid_o   <= res_valid_q;
      sample_taken_o  <= res_taken_q;
      average_ready_o <= res_ready_q;
      if (!res_ready_q) begin
        pm25_average_o <= '0;
        pm10_average_o <= '0;
      end else begin
        pm25_average_o <= (quo25_q[SumW-1:AvgW] != '0) ? '1 : quo25_q[AvgW-1:0];
        pm10_average_o <= (quo10_q[SumW-1:AvgW] != '0) ? '1 : quo10_q[AvgW-1:0];
      end
    end
  end

  // The position never rests beyond the wrap point.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.eval) |-> (pos_q < PositionWrap))
    else $error("position left its range after evaluation");

  // An emitted average always comes with a taken sample of a good frame.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.out_load) && average_ready_o |-> (sample_taken_o && frame_valid_o))
    else $error("average flagged without a taken sample");

endmodule

`default_nettype wire

### rtl/dust_sensor_frame_averager.sv
// Top level of the dust sensor frame averager: stream ports, controller and
// datapath. Depends on dsfa_pkg, dsfa_ctrl and dsfa_datapath.
//
//  Channel  Direction  Beat contents
//  s_axis   in         tdata[7:0] rx_byte, tuser[0] measurement_window
//  m_axis   out        tdata[15:0] pm25_average, tdata[31:16] pm10_average,
//                      tuser[0] frame_valid, [1] sample_taken, [2] average_ready
//  cfg      in         cfg_data_i[7:0] samples_per_average
//
// Every input beat yields exactly one output beat. A beat passes through the
// evaluation, and through the bit-serial divider (one quotient bit per cycle)
// when an average is emitted, before it reaches the output register. The input
// reopens in that same cycle, so a new beat is taken only once the last one has
// reached the output register.
// Reset clears position, sums and count; the window needs no clearing.
// A stalled output holds its beat while the next input beat is accepted and
// evaluated; that beat waits in the datapath until the output frees up.
`timescale 1ns / 1ps
`default_nettype none

module dust_sensor_frame_averager #(
  parameter logic [7:0] PositionWrap = dsfa_pkg::PositionWrap
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire [0:0]  s_axis_tuser,   // [0] measurement_window
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] pm25_average, [31:16] pm10_average
  output logic [2:0] m_axis_tuser,   // [0] frame_valid, [1] sample_taken, [2] average_ready
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [7:0]  cfg_data_i      // samples_per_average
);

  dsfa_pkg::dp_cmd_t  cmd;
  dsfa_pkg::dp_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  dsfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  dsfa_datapath #(
    .PositionWrap (PositionWrap)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .cfg_we_i             (cfg_valid_i),
    .cfg_data_i           (cfg_data_i),
    .rx_byte_i            (s_axis_tdata),
    .measurement_window_i (s_axis_tuser[0]),
    .frame_valid_o        (m_axis_tuser[0]),
    .sample_taken_o       (m_axis_tuser[1]),
    .average_ready_o      (m_axis_tuser[2]),
    .pm25_average_o       (m_axis_tdata[15:0]),
    .pm10_average_o       (m_axis_tdata[31:16])
  );

endmodule

`default_nettype wire

### test/dsfa_average_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the dust sensor frame averager: follows the input, output and
// configuration channels, predicts every output beat and compares it field by
// field. Depends on dsfa_pkg.

module dsfa_average_checker
  import dsfa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tready_i,
  input  logic [7:0]        s_tdata_i,
  input  logic [0:0]        s_tuser_i,
  input  logic              m_tvalid_i,
  input  logic              m_tready_i,
  input  logic [31:0]       m_tdata_i,
  input  logic [2:0]        m_tuser_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [7:0]        cfg_data_i,
  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o
);

  typedef struct packed {
    logic        frame_valid;
    logic        sample_taken;
    logic        average_ready;
    logic [15:0] pm25_average;
    logic [15:0] pm10_average;
  } avg_beat_t;

  // Shadow copy of the block's register and state.
  logic [7:0]      samples_per_avg;
  logic [7:0]      rx_window [FrameLen];
  logic [7:0]      stored_pos;
  logic [SumW-1:0] pm25_sum;
  logic [SumW-1:0] pm10_sum;
  logic [7:0]      sample_count;

  avg_beat_t   pending_beats [$];
  avg_beat_t   oldest_beat;
  int unsigned mismatch_count;

  // Advances the shadow state by one received byte and returns the beat the
  // block has to produce for it.
  function automatic avg_beat_t predict_beat(input logic [7:0] rx, input logic in_window);
    avg_beat_t       beat;
    int unsigned     pos;
    int unsigned     k;
    logic [7:0]      csum;
    logic [7:0]      need;
    logic [SumW-1:0] divisor;
    logic [SumW-1:0] q25;
    logic [SumW-1:0] q10;
    beat = '0;
    pos  = stored_pos;
    // Bytes are only kept once a start byte has opened a frame.
    if (pos != 0 || rx == StartByte) begin
      for (k = 0; k < FrameLen - 1; k++) rx_window[k] = rx_window[k + 1];
      rx_window[FrameLen - 1] = rx;
      pos++;
    end
    csum = '0;
    for (k = 2; k <= 7; k++) csum = csum + rx_window[k];
    if (rx == TailByte && pos >= FrameLen && rx_window[0] == StartByte &&
        rx_window[1] == CmdByte && rx_window[9] == TailByte && rx_window[8] == csum) begin
      beat.frame_valid = 1'b1;
      pos = 0;
      if (in_window) begin
        beat.sample_taken = 1'b1;
        pm25_sum     = pm25_sum + {8'h00, rx_window[3], rx_window[2]};
        pm10_sum     = pm10_sum + {8'h00, rx_window[5], rx_window[4]};
        sample_count = sample_count + 8'd1;
        // A register value of zero behaves like one.
        need = (samples_per_avg == 8'd0) ? 8'd1 : samples_per_avg;
        if (sample_count >= need || sample_count == CountLimit) begin
          divisor = (sample_count == 8'd0) ? SumW'(1) : SumW'(sample_count);
          q25 = pm25_sum / divisor;
          q10 = pm10_sum / divisor;
          beat.average_ready = 1'b1;
          beat.pm25_average  = (q25 > SumW'(16'hFFFF)) ? 16'hFFFF : q25[15:0];
          beat.pm10_average  = (q10 > SumW'(16'hFFFF)) ? 16'hFFFF : q10[15:0];
          pm25_sum     = '0;
          pm10_sum     = '0;
          sample_count = '0;
        end
      end
    end
    stored_pos = 8'(pos % PositionWrap);
    return beat;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Output beats are matched before new input beats are predicted; an output
  // beat always belongs to an earlier input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_per_avg = SamplesReset;
      foreach (rx_window[k]) rx_window[k] = '0;
      stored_pos      = '0;
      pm25_sum        = '0;
      pm10_sum        = '0;
      sample_count    = '0;
      pending_beats.delete();
      mismatch_count  = 0;
      mismatches_o   <= 0;
      outstanding_o  <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (pending_beats.size() == 0) begin
          $display("%0t ns: output beat with none expected, actual tuser %b tdata %h",
                   $time, m_tuser_i, m_tdata_i);
          mismatch_count++;
        end else begin
          oldest_beat = pending_beats.pop_front();
          check_field("frame_valid", 16'(oldest_beat.frame_valid), 16'(m_tuser_i[0]));
          check_field("sample_taken", 16'(oldest_beat.sample_taken), 16'(m_tuser_i[1]));
          check_field("average_ready", 16'(oldest_beat.average_ready), 16'(m_tuser_i[2]));
          check_field("pm25_average", oldest_beat.pm25_average, m_tdata_i[15:0]);
          check_field("pm10_average", oldest_beat.pm10_average, m_tdata_i[31:16]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) samples_per_avg = cfg_data_i;
      if (s_tvalid_i && s_tready_i) pending_beats.push_back(predict_beat(s_tdata_i, s_tuser_i[0]));
      mismatches_o  <= mismatch_count;
      outstanding_o <= pending_beats.size();
    end
  end

endmodule

### test/tb_dust_sensor_frame_averager.sv
`timescale 1ns / 1ps
// Testbench top for the dust sensor frame averager: clock, reset, byte and
// configuration stimulus, output back-pressure and the verdict.
// Depends on dsfa_pkg, dust_sensor_frame_averager and dsfa_average_checker.

module tb_dust_sensor_frame_averager;
  import dsfa_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 32;

  typedef enum logic [2:0] {
    FrmGood, FrmBadSum, FrmBadCmd, FrmDropByte, FrmShort, FrmNoise
  } frame_kind_e;

  typedef enum logic [1:0] {FillRandom, FillZero, FillOnes, FillMixed} fill_e;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;
  logic [0:0]  s_axis_tuser   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i     = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles;

  // When calm is set neither side inserts gaps.
  bit calm         = 1'b0;
  bit hold_off_req = 1'b0;

  always #5 clk_i = ~clk_i;

  dust_sensor_frame_averager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  dsfa_average_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Reset is held at the start and never again.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog: ends the run when no channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_dust_sensor_frame_averager NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: a random gap before each beat, and one long hold-off on request.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] rx, input logic in_window);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tuser  <= in_window;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Builds a sensor frame with a correct checksum, then damages it as asked.
  task automatic send_frame(input frame_kind_e kind, input fill_e fill, input logic in_window);
    logic [7:0]  frame_bytes [FrameLen];
    logic [7:0]  csum;
    int unsigned k;
    int unsigned drop_at;
    int unsigned n_bytes;
    frame_bytes[0] = StartByte;
    frame_bytes[1] = CmdByte;
    csum = '0;
    for (k = 2; k <= 7; k++) begin
      case (fill)
        FillZero:  frame_bytes[k] = 8'h00;
        FillOnes:  frame_bytes[k] = 8'hFF;
        FillMixed: frame_bytes[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:   frame_bytes[k] = 8'($urandom_range(0, 255));
      endcase
      csum = csum + frame_bytes[k];
    end
    frame_bytes[8] = csum;
    frame_bytes[9] = TailByte;
    drop_at = FrameLen;
    n_bytes = FrameLen;
    case (kind)
      FrmBadSum:   frame_bytes[8] = csum ^ (8'h01 << $urandom_range(0, 7));
      FrmBadCmd:   frame_bytes[1] = CmdByte ^ 8'($urandom_range(1, 255));
      FrmDropByte: drop_at = $urandom_range(1, 8);
      FrmShort:    n_bytes = $urandom_range(1, 9);
      default: ;
    endcase
    if (kind == FrmNoise) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), in_window);
    end else begin
      for (k = 0; k < n_bytes; k++) begin
        if (k != drop_at) send_byte(frame_bytes[k], in_window);
      end
    end
  endtask

  // Mostly good frames, with broken frames and line noise mixed in.
  task automatic random_frames(input int unsigned count);
    int unsigned pick;
    frame_kind_e kind;
    fill_e       fill;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      pick = $urandom_range(0, 19);
      fill = FillRandom;
      if (pick <= 11) begin
        kind = FrmGood;
      end else if (pick <= 13) begin
        kind = FrmGood;
        fill = FillMixed;
      end else begin
        case (pick)
          14:      kind = FrmBadSum;
          15:      kind = FrmBadCmd;
          16:      kind = FrmDropByte;
          17:      kind = FrmShort;
          default: kind = FrmNoise;
        endcase
      end
      send_frame(kind, fill, $urandom_range(0, 6) != 0);
    end
  endtask

  // Stops offering beats until every expected output beat has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_samples(input logic [7:0] samples);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= samples;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Bytes before any start byte are dropped, a tail byte included.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(TailByte, 1'b1);
    // A stray start byte ahead of a frame with the largest readings.
    send_byte(StartByte, 1'b1);
    send_byte(8'h55, 1'b1);
    send_frame(FrmGood, FillOnes, 1'b1);
    // A good frame outside the measurement window.
    send_frame(FrmGood, FillZero, 1'b0);

    // A long run without a good frame makes the position wrap.
    send_byte(StartByte, 1'b1);
    repeat (254) send_byte(8'($urandom_range(0, 255)), 1'b1);
    random_frames(4);

    // The output stalls for a long time while the input keeps offering.
    calm         = 1'b1;
    hold_off_req = 1'b1;
    random_frames(3);
    calm         = 1'b0;

    load_samples(8'd1);
    random_frames(6);
    load_samples(8'd0);
    random_frames(5);

    // Largest setting, then lowered while samples are already summed.
    load_samples(8'd255);
    repeat (6) send_frame(FrmGood, FillRandom, 1'b1);
    load_samples(8'd2);
    random_frames(6);

    load_samples(8'($urandom_range(3, 6)));
    random_frames(12);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb_dust_sensor_frame_averager OK");
    end else begin
      $display("tb_dust_sensor_frame_averager NOT OK");
    end
    $finish;
  end

endmodule
